FILE: rtl/cbbp_pkg.sv
// shared constants, types and the arctangent table of the compass bearing block
package cbbp_pkg;

  localparam int COORD_WIDTH_DEF     = 24;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;

  localparam int TABLE_FRAC = 24;
  localparam int TABLE_LEN  = 24;
  localparam int NORM_BIT   = 40;
  localparam int NORM_W     = NORM_BIT + 1;
  localparam int XY_W       = NORM_W + 4;
  localparam int Z_W        = 32;

  typedef struct packed {
    logic sx;
    logic sy;
    logic zx;
    logic zy;
  } quad_flags_t;

  function automatic logic signed [Z_W-1:0] atan_q24(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = 32'sd754974720;
      1:       v = 32'sd445687602;
      2:       v = 32'sd235489088;
      3:       v = 32'sd119537938;
      4:       v = 32'sd60000934;
      5:       v = 32'sd30029717;
      6:       v = 32'sd15018523;
      7:       v = 32'sd7509720;
      8:       v = 32'sd3754917;
      9:       v = 32'sd1877466;
      10:      v = 32'sd938734;
      11:      v = 32'sd469367;
      12:      v = 32'sd234684;
      13:      v = 32'sd117342;
      14:      v = 32'sd58671;
      15:      v = 32'sd29335;
      16:      v = 32'sd14668;
      17:      v = 32'sd7334;
      18:      v = 32'sd3667;
      19:      v = 32'sd1833;
      20:      v = 32'sd917;
      21:      v = 32'sd458;
      22:      v = 32'sd229;
      23:      v = 32'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/compass_bearing_between_points.sv
// compass bearing from an origin point to a target point, pipelined cordic
//
// Each input beat carries origin and target coordinates. The output beat carries the
// clockwise bearing (0 toward +y, 90 toward +x) in units of 2^-ANGLE_FRAC_BITS degree.
// tuser flags coincident points, which read as 270 degrees. One beat is taken every
// clock cycle while tready is high. A beat passes CORDIC_STEPS + 7 registers: differences,
// magnitudes, two for normalization, one per cordic iteration, clamp and rounding,
// quadrant map and the output register. A two-entry output buffer lets the pipeline
// keep moving while one result waits; tready drops only once a second result is held.
module compass_bearing_between_points #(
  parameter int COORD_WIDTH     = cbbp_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS    = cbbp_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = cbbp_pkg::ANGLE_FRAC_BITS_DEF,
  localparam int IN_W   = ((4 * COORD_WIDTH + 7) / 8) * 8,
  localparam int BEAR_W = $clog2(360 << ANGLE_FRAC_BITS),
  localparam int OUT_W  = ((BEAR_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // origin_x, origin_y, target_x, target_y
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // bearing
  output logic [OUT_W-1:0] m_axis_tdata_o,
  // coincident
  output logic             m_axis_tuser_o
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int NW = cbbp_pkg::NORM_W;
  localparam int XW = cbbp_pkg::XY_W;
  localparam int ZW = cbbp_pkg::Z_W;
  localparam int SH = cbbp_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;

  localparam int P_RND = 4 + CORDIC_STEPS;
  localparam int NS    = 6 + CORDIC_STEPS;

  localparam logic [BEAR_W-1:0] U90  = BEAR_W'(90 << ANGLE_FRAC_BITS);
  localparam logic [BEAR_W-1:0] U180 = BEAR_W'(180 << ANGLE_FRAC_BITS);
  localparam logic [BEAR_W-1:0] U270 = BEAR_W'(270 << ANGLE_FRAC_BITS);
  localparam logic [BEAR_W-1:0] FULL = BEAR_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] Z90  = ZW'(90 << cbbp_pkg::TABLE_FRAC);
  localparam logic [ZW-1:0]        HALF = ZW'(1) << (SH - 1);

  logic                  en;
  logic [NS-1:0]         vld_q;
  cbbp_pkg::quad_flags_t flg_q [NS];
  cbbp_pkg::quad_flags_t flg_w;

  // input fields and differences
  logic [CW-1:0]        ox, oy, tx, ty;
  logic signed [DW-1:0] dx_w, dy_w, dx_q, dy_q;

  // magnitudes
  logic [CW-1:0] ax_w, ay_w, ax_q, ay_q, big_q;

  // normalization
  logic [NW-1:0] na_x_w, na_y_w, na_b_w, na_x_q, na_y_q, na_b_q;
  logic [NW-1:0] nb_x_w, nb_y_w, nb_b_w;

  // cordic
  logic signed [XW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS:1];

  // rounding and quadrant map
  logic signed [ZW-1:0] zc_w;
  logic [ZW-1:0]        zr_w;
  logic [BEAR_W-1:0]    b_w, b_q;
  logic [BEAR_W-1:0]    bear_w, bear_q;
  logic                 coin_w, coin_q;

  // output buffer
  logic              take;
  logic              out_vld_q, skid_vld_q;
  logic [BEAR_W-1:0] out_bear_q, skid_bear_q;
  logic              out_coin_q, skid_coin_q;

  assign en              = !skid_vld_q;
  assign s_axis_tready_o = en;
  assign take            = en && vld_q[NS-1];

  // valid bits travel with the beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flg_q[0] <= flg_w;
      for (int k = 1; k < NS; k++) begin
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  // stage: differences
  assign ox   = s_axis_tdata_i[0*CW +: CW];
  assign oy   = s_axis_tdata_i[1*CW +: CW];
  assign tx   = s_axis_tdata_i[2*CW +: CW];
  assign ty   = s_axis_tdata_i[3*CW +: CW];
  assign dx_w = $signed({tx[CW-1], tx}) - $signed({ox[CW-1], ox});
  assign dy_w = $signed({ty[CW-1], ty}) - $signed({oy[CW-1], oy});

  always_comb begin
    flg_w.sx = dx_w[DW-1];
    flg_w.sy = dy_w[DW-1];
    flg_w.zx = (tx == ox);
    flg_w.zy = (ty == oy);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= dx_w;
      dy_q <= dy_w;
    end
  end

  // stage: magnitudes, cordic runs on x = |dy| and y = |dx|
  assign ax_w = dy_q[DW-1] ? CW'(-dy_q) : CW'(dy_q);
  assign ay_w = dx_q[DW-1] ? CW'(-dx_q) : CW'(dx_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q  <= ax_w;
      ay_q  <= ay_w;
      big_q <= (ax_w > ay_w) ? ax_w : ay_w;
    end
  end

  // stage: normalize by 32, 16, 8
  always_comb begin
    na_x_w = NW'(ax_q);
    na_y_w = NW'(ay_q);
    na_b_w = NW'(big_q);
    for (int j = 0; j < 3; j++) begin
      if ((na_b_w >> (NW - (32 >> j))) == '0) begin
        na_x_w = na_x_w << (32 >> j);
        na_y_w = na_y_w << (32 >> j);
        na_b_w = na_b_w << (32 >> j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      na_x_q <= na_x_w;
      na_y_q <= na_y_w;
      na_b_q <= na_b_w;
    end
  end

  // stage: normalize by 4, 2, 1
  always_comb begin
    nb_x_w = na_x_q;
    nb_y_w = na_y_q;
    nb_b_w = na_b_q;
    for (int j = 0; j < 3; j++) begin
      if ((nb_b_w >> (NW - (4 >> j))) == '0) begin
        nb_x_w = nb_x_w << (4 >> j);
        nb_y_w = nb_y_w << (4 >> j);
        nb_b_w = nb_b_w << (4 >> j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0] <= $signed(XW'(nb_x_w));
      y_q[0] <= $signed(XW'(nb_y_w));
    end
  end

  // cordic iterations, one per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys, x_d, y_d;
    logic signed [ZW-1:0] z_in, z_d;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    if (i == 0) begin : g_z0
      assign z_in = '0;
    end else begin : g_zn
      assign z_in = z_q[i];
    end

    always_comb begin
      if (!y_q[i][XW-1]) begin
        x_d = x_q[i] + ys;
        y_d = y_q[i] - xs;
        z_d = z_in + cbbp_pkg::atan_q24(i);
      end else begin
        x_d = x_q[i] - ys;
        y_d = y_q[i] + xs;
        z_d = z_in - cbbp_pkg::atan_q24(i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        x_q[i+1] <= x_d;
        y_q[i+1] <= y_d;
        z_q[i+1] <= z_d;
      end
    end
  end

  // stage: clamp to [0, 90] and round half up
  always_comb begin
    zc_w = z_q[CORDIC_STEPS];
    if (zc_w < 0) begin
      zc_w = '0;
    end else if (zc_w > Z90) begin
      zc_w = Z90;
    end
    zr_w = $unsigned(zc_w) + HALF;
    b_w  = BEAR_W'(zr_w >> SH);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q <= b_w;
    end
  end

  // stage: quadrant map and wrap
  always_comb begin
    coin_w = 1'b0;
    if (flg_q[P_RND].zx && flg_q[P_RND].zy) begin
      bear_w = U270;
      coin_w = 1'b1;
    end else if (flg_q[P_RND].zx) begin
      bear_w = flg_q[P_RND].sy ? U180 : '0;
    end else if (flg_q[P_RND].zy) begin
      bear_w = flg_q[P_RND].sx ? U270 : U90;
    end else if (!flg_q[P_RND].sx) begin
      bear_w = flg_q[P_RND].sy ? (U180 - b_q) : b_q;
    end else begin
      bear_w = flg_q[P_RND].sy ? (U180 + b_q) : (FULL - b_q);
    end
    if (bear_w >= FULL) begin
      bear_w = bear_w - FULL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bear_q <= bear_w;
      coin_q <= coin_w;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready_i) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= take;
      end
    end else if (take) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready_i) begin
      if (skid_vld_q) begin
        out_bear_q <= skid_bear_q;
        out_coin_q <= skid_coin_q;
      end else if (take) begin
        out_bear_q <= bear_q;
        out_coin_q <= coin_q;
      end
    end else if (take) begin
      skid_bear_q <= bear_q;
      skid_coin_q <= coin_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_W'(out_bear_q);
  assign m_axis_tuser_o  = out_coin_q;

`ifndef SYNTH
  a_coin_270: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[BEAR_W-1:0] == U270)
    else $error("coincident beat without 270 degree bearing");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[BEAR_W-1:0] < FULL)
    else $error("bearing not below full circle");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result waiting");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> out_vld_q)
    else $error("output register empty after skid entry held a beat");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted beat missing from first stage");
`endif

endmodule
